// File: rtl/core/icv_pkg.sv
// Constants and helper functions for the IPv4 CIDR text checker.
`default_nettype none

package icv_pkg;

    // Character codes the parser recognizes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Limits of the address format.
    localparam logic [8:0] OCTET_MAX     = 9'd255;
    localparam logic [8:0] OCTET_SAT     = 9'd256;
    localparam logic [5:0] PREFIX_MAX    = 6'd32;
    localparam logic [5:0] PREFIX_SAT    = 6'd33;
    localparam logic [4:0] ADDR_LEN_MAX  = 5'd15;
    localparam logic [4:0] ADDR_LEN_SAT  = 5'd16;
    localparam logic [2:0] OCTET_COUNT   = 3'd4;
    localparam logic [2:0] OCTETS_SAT    = 3'd5;

    // Octet value after one more decimal digit, saturating at OCTET_SAT.
    function automatic logic [8:0] octet_shift_in(input logic [8:0] accum,
                                                  input logic [3:0] digit);
        logic [11:0] v;
        v = ({3'b000, accum} << 3) + ({3'b000, accum} << 1) + {8'h00, digit};
        return (v > {3'b000, OCTET_SAT}) ? OCTET_SAT : v[8:0];
    endfunction

    // Prefix value after one more decimal digit, saturating at PREFIX_SAT.
    function automatic logic [5:0] prefix_shift_in(input logic [5:0] accum,
                                                   input logic [3:0] digit);
        logic [8:0] v;
        v = ({3'b000, accum} << 3) + ({3'b000, accum} << 1) + {5'h00, digit};
        return (v > {3'b000, PREFIX_SAT}) ? PREFIX_SAT : v[5:0];
    endfunction

    // An octet that closes is bad if it is empty, too large, or out of place.
    // A final octet must be the fourth; an inner one must come before it.
    function automatic logic octet_close_err(input logic       seen,
                                             input logic [8:0] accum,
                                             input logic [2:0] done,
                                             input logic       is_final);
        logic bad_value;
        logic bad_place;
        bad_value = !seen || (accum > OCTET_MAX);
        bad_place = is_final ? (done != (OCTET_COUNT - 3'd1))
                             : (done >= (OCTET_COUNT - 3'd1));
        return bad_value || bad_place;
    endfunction

    // Count of closed octets, saturating at OCTETS_SAT.
    function automatic logic [2:0] octets_inc(input logic [2:0] done);
        return (done < OCTETS_SAT) ? done + 3'd1 : done;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ipv4_cidr_text_validator.sv
// Top level of the IPv4 dotted-quad text checker with optional CIDR prefix.
// The last character passes from the input register into the result register,
// which then offers the result on the output channel.
// Throughput: one character per cycle; only a last character waits, and only
// while an earlier result is held in the result register by a stalled output.
// Reset (synchronous, active low) clears the parse state, the valid flags of both
// pipeline registers and the mode register, which comes up in bare-address mode.
`default_nettype none

module ipv4_cidr_text_validator (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Mode register write port
    input  wire logic       i_require_prefix_we,
    input  wire logic       i_require_prefix,
    // Character input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_last_char,
    // Result output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_is_valid
);

    // Mode register
    logic       r_require_prefix;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // Parse state
    logic       r_in_prefix_part, n_in_prefix_part;
    logic [4:0] r_address_length, n_address_length;
    logic [8:0] r_octet_accum,    n_octet_accum;
    logic       r_octet_seen,     n_octet_seen;
    logic [2:0] r_octets_done,    n_octets_done;
    logic [5:0] r_prefix_accum,   n_prefix_accum;
    logic       r_prefix_seen,    n_prefix_seen;
    logic       r_error_seen,     n_error_seen;

    // Result register
    logic       r_out_valid;
    logic       r_out_is_valid;

    logic       advance;
    logic       in_xfer;
    logic       is_digit;
    logic [3:0] digit;

    // A character without a result always moves on; the last one needs
    // room in the result register.
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_xfer = i_valid && !o_stall;

    assign is_digit = (r_in_char >= icv_pkg::CHAR_ZERO) && (r_in_char <= icv_pkg::CHAR_NINE);
    assign digit    = is_digit ? 4'(r_in_char - icv_pkg::CHAR_ZERO) : 4'd0;

    // Next parse state for the character in the input register.
    always_comb begin
        n_in_prefix_part = r_in_prefix_part;
        n_address_length = r_address_length;
        n_octet_accum    = r_octet_accum;
        n_octet_seen     = r_octet_seen;
        n_octets_done    = r_octets_done;
        n_prefix_accum   = r_prefix_accum;
        n_prefix_seen    = r_prefix_seen;
        n_error_seen     = r_error_seen;

        if (!r_in_prefix_part) begin
            if ((r_in_char == icv_pkg::CHAR_SLASH) && r_require_prefix) begin
                // The slash closes the fourth octet and opens the prefix.
                if (icv_pkg::octet_close_err(r_octet_seen, r_octet_accum,
                                             r_octets_done, 1'b1)) begin
                    n_error_seen = 1'b1;
                end
                n_octets_done    = icv_pkg::octets_inc(r_octets_done);
                n_octet_accum    = '0;
                n_octet_seen     = 1'b0;
                n_in_prefix_part = 1'b1;
            end else begin
                if (r_address_length < icv_pkg::ADDR_LEN_SAT) begin
                    n_address_length = r_address_length + 5'd1;
                end
                if (n_address_length > icv_pkg::ADDR_LEN_MAX) begin
                    n_error_seen = 1'b1;
                end
                if (is_digit) begin
                    n_octet_accum = icv_pkg::octet_shift_in(r_octet_accum, digit);
                    n_octet_seen  = 1'b1;
                end else if (r_in_char == icv_pkg::CHAR_DOT) begin
                    if (icv_pkg::octet_close_err(r_octet_seen, r_octet_accum,
                                                 r_octets_done, 1'b0)) begin
                        n_error_seen = 1'b1;
                    end
                    n_octets_done = icv_pkg::octets_inc(r_octets_done);
                    n_octet_accum = '0;
                    n_octet_seen  = 1'b0;
                end else begin
                    n_error_seen = 1'b1;
                end
            end
        end else begin
            if (is_digit) begin
                n_prefix_accum = icv_pkg::prefix_shift_in(r_prefix_accum, digit);
                n_prefix_seen  = 1'b1;
            end else begin
                n_error_seen = 1'b1;
            end
        end

        // End of string: the part reached must match the mode.
        if (r_in_last) begin
            if (!n_in_prefix_part) begin
                if (r_require_prefix) begin
                    n_error_seen = 1'b1;
                end else if (icv_pkg::octet_close_err(n_octet_seen, n_octet_accum,
                                                      n_octets_done, 1'b1)) begin
                    n_error_seen = 1'b1;
                end
            end else begin
                if (!r_require_prefix) begin
                    n_error_seen = 1'b1;
                end
                if (!n_prefix_seen || (n_prefix_accum > icv_pkg::PREFIX_MAX)) begin
                    n_error_seen = 1'b1;
                end
            end
        end
    end

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_prefix <= 1'b0;
        end else if (i_require_prefix_we) begin
            r_require_prefix <= i_require_prefix;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    // Parse state: updated per character, cleared after each result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_in_prefix_part <= 1'b0;
            r_address_length <= '0;
            r_octet_accum    <= '0;
            r_octet_seen     <= 1'b0;
            r_octets_done    <= '0;
            r_prefix_accum   <= '0;
            r_prefix_seen    <= 1'b0;
            r_error_seen     <= 1'b0;
        end else if (advance) begin
            r_in_prefix_part <= n_in_prefix_part;
            r_address_length <= n_address_length;
            r_octet_accum    <= n_octet_accum;
            r_octet_seen     <= n_octet_seen;
            r_octets_done    <= n_octets_done;
            r_prefix_accum   <= n_prefix_accum;
            r_prefix_seen    <= n_prefix_seen;
            r_error_seen     <= n_error_seen;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_is_valid <= !n_error_seen;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_is_valid = r_out_is_valid;

`ifndef ASSERT_OFF
    // Saturating counters never pass their ceilings.
    a_sat_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_octet_accum <= icv_pkg::OCTET_SAT) && (r_prefix_accum <= icv_pkg::PREFIX_SAT)
        && (r_octets_done <= icv_pkg::OCTETS_SAT)
        && (r_address_length <= icv_pkg::ADDR_LEN_SAT))
        else $error("parse counter beyond its saturation value");

    // The end of a string leaves the parse state clear for the next one.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (!r_in_prefix_part && (r_octets_done == 3'd0)
        && !r_error_seen && (r_address_length == 5'd0)))
        else $error("parse state not cleared after a result");

    // A final character is taken in only when the result register has room.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && r_in_valid && r_in_last) |=> $stable(r_out_is_valid))
        else $error("pending result overwritten");

    // The prefix part is only ever entered from the address part at a slash.
    a_prefix_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_in_prefix_part) |-> ($past(r_in_char) == icv_pkg::CHAR_SLASH))
        else $error("prefix part entered without a slash");
`endif

endmodule

`default_nettype wire

// File: verif/ipv4_cidr_text_validator_test.sv
// Self-checking testbench for the IPv4 dotted-quad and CIDR text checker.
`default_nettype none

module ipv4_cidr_text_validator_test;

    // Character codes and format limits used by the address predictor.
    localparam logic [7:0] ZERO_CODE  = 8'h30;
    localparam logic [7:0] NINE_CODE  = 8'h39;
    localparam logic [7:0] DOT_CODE   = 8'h2E;
    localparam logic [7:0] SLASH_CODE = 8'h2F;
    localparam int OCTET_TOP     = 255;
    localparam int OCTET_CEIL    = 256;
    localparam int PREFIX_TOP    = 32;
    localparam int PREFIX_CEIL   = 33;
    localparam int ADDR_TEXT_MAX = 15;
    localparam int ADDR_TEXT_CAP = 16;
    localparam int OCTET_LAST    = 3;
    localparam int OCTET_CAP     = 5;

    // In the probe table these two marks stand for the codes 8'h00 and 8'hFF.
    localparam logic [7:0] NUL_MARK = "^";
    localparam logic [7:0] TOP_MARK = "~";

    // A probe whose verdict is not typed in is judged by the predictor.
    localparam int PREDICTED      = -1;
    localparam int RANDOM_CHARS   = 1180;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 600;

    typedef enum int {EDIT_REPLACE, EDIT_DROP, EDIT_DOT, EDIT_SLASH} t_edit;

    typedef struct {
        bit    mode;
        string text;
        int    verdict;
    } t_probe;

    // Directed strings: extremes, every special case, and both modes.
    t_probe probes [0:27] = '{
        '{1'b0, "0.0.0.0",            1},
        '{1'b0, "255.255.255.255",    1},
        '{1'b0, "000.001.010.099",    1},
        '{1'b0, "0000.1.1.1",         PREDICTED},
        '{1'b0, "256.1.1.1",          0},
        '{1'b0, ".1.2.3.4",           0},
        '{1'b0, "1.2.3.4.",           0},
        '{1'b0, "1..2.3.4",           0},
        '{1'b0, "1.2.3",              0},
        '{1'b0, "1.2.3.4.5",          0},
        '{1'b0, "1.2.3.4/24",         0},
        '{1'b0, "1.2.3.a",            0},
        '{1'b0, "1.2.3.9999999999",   0},
        '{1'b0, "0001.0002.0003.4",   0},
        '{1'b0, "1.2.3.4^",           0},
        '{1'b0, "~",                  0},
        '{1'b1, "1.2.3.4/0",          1},
        '{1'b1, "255.255.255.255/32", 1},
        '{1'b1, "1.2.3.4/032",        1},
        '{1'b1, "10.20.30.40/17",     PREDICTED},
        '{1'b1, "1.2.3.4/33",         0},
        '{1'b1, "1.2.3.4/",           0},
        '{1'b1, "1.2.3.4//8",         0},
        '{1'b1, "1.2.3.4/999999",     0},
        '{1'b1, "1.2.3.4",            0},
        '{1'b1, "1.2.3/8",            0},
        '{1'b1, "1.2.3.4/1.2",        0},
        '{1'b1, "/8",                 0}
    };

    // Block ports; the inputs are all known from time zero.
    logic       i_clk               = 1'b0;
    logic       i_rst_n             = 1'b0;
    logic       i_require_prefix_we = 1'b0;
    logic       i_require_prefix    = 1'b0;
    logic       i_valid             = 1'b0;
    logic       o_stall;
    logic [7:0] i_char_code         = 8'h00;
    logic       i_last_char         = 1'b0;
    logic       o_valid;
    logic       i_stall             = 1'b0;
    logic       o_is_valid;

    // Predictor copy of the mode register and of the parse state.
    bit         prefix_mode;
    bit         in_prefix;
    logic [4:0] addr_chars;
    logic [8:0] octet_value;
    bit         octet_has_digit;
    logic [2:0] octets_closed;
    logic [5:0] prefix_value;
    bit         prefix_has_digit;
    bit         string_bad;

    // Verdicts waiting for their result transfer, and the typed-in ones per string.
    bit         expected_verdicts[$];
    int         pinned_verdicts[$];
    logic [7:0] text_q[$];

    int         mismatches;
    int         send_streak;
    int         stall_streak;
    int         stall_left;
    int         idle_cycles;

    ipv4_cidr_text_validator uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_require_prefix_we (i_require_prefix_we),
        .i_require_prefix    (i_require_prefix),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_char_code         (i_char_code),
        .i_last_char         (i_last_char),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_is_valid          (o_is_valid)
    );

    always #2 i_clk = ~i_clk;

    // Wait drawn per transfer: a random wait, with occasional runs of no wait at all.
    function automatic int draw_wait(inout int streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            streak = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Closing an octet checks its value and its place among the four.
    function automatic void close_octet(input bit is_final);
        if (!octet_has_digit || octet_value > OCTET_TOP)
            string_bad = 1'b1;
        if (is_final ? (octets_closed != OCTET_LAST) : (octets_closed >= OCTET_LAST))
            string_bad = 1'b1;
        if (octets_closed < OCTET_CAP)
            octets_closed = octets_closed + 3'd1;
        octet_value     = '0;
        octet_has_digit = 1'b0;
    endfunction

    // Advance the parse by one character; returns 1 when the string ends.
    function automatic bit parse_char(input logic [7:0] code, input logic last,
                                      output bit verdict);
        bit is_digit;
        int digit;
        int grown;
        is_digit = (code >= ZERO_CODE) && (code <= NINE_CODE);
        digit    = is_digit ? int'(code - ZERO_CODE) : 0;
        verdict  = 1'b0;
        if (!in_prefix) begin
            if (code == SLASH_CODE && prefix_mode) begin
                close_octet(1'b1);
                in_prefix = 1'b1;
            end else begin
                if (addr_chars < ADDR_TEXT_CAP)
                    addr_chars = addr_chars + 5'd1;
                if (addr_chars > ADDR_TEXT_MAX)
                    string_bad = 1'b1;
                if (is_digit) begin
                    grown           = int'(octet_value) * 10 + digit;
                    octet_value     = (grown > OCTET_CEIL) ? 9'(OCTET_CEIL) : 9'(grown);
                    octet_has_digit = 1'b1;
                end else if (code == DOT_CODE) begin
                    close_octet(1'b0);
                end else begin
                    string_bad = 1'b1;
                end
            end
        end else if (is_digit) begin
            grown            = int'(prefix_value) * 10 + digit;
            prefix_value     = (grown > PREFIX_CEIL) ? 6'(PREFIX_CEIL) : 6'(grown);
            prefix_has_digit = 1'b1;
        end else begin
            string_bad = 1'b1;
        end

        if (!last)
            return 1'b0;

        // The part reached must match the mode in force at the last character.
        if (!in_prefix) begin
            if (prefix_mode)
                string_bad = 1'b1;
            else
                close_octet(1'b1);
        end else begin
            if (!prefix_mode)
                string_bad = 1'b1;
            if (!prefix_has_digit || prefix_value > PREFIX_TOP)
                string_bad = 1'b1;
        end
        verdict = !string_bad;

        in_prefix        = 1'b0;
        addr_chars       = '0;
        octet_value      = '0;
        octet_has_digit  = 1'b0;
        octets_closed    = '0;
        prefix_value     = '0;
        prefix_has_digit = 1'b0;
        string_bad       = 1'b0;
        return 1'b1;
    endfunction

    // Character transfers feed the predictor; result transfers are checked.
    always @(posedge i_clk) begin : transfer_monitor
        bit ends;
        bit verdict;
        int pinned;
        if (i_rst_n && i_valid && !o_stall) begin
            ends = parse_char(i_char_code, i_last_char, verdict);
            if (ends) begin
                pinned = pinned_verdicts.pop_front();
                expected_verdicts.push_back((pinned == PREDICTED) ? verdict : (pinned != 0));
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %0b",
                         $time, o_is_valid);
                mismatches++;
            end else begin
                verdict = expected_verdicts.pop_front();
                if (o_is_valid !== verdict) begin
                    $display("%0t: is_valid mismatch, expected %0b, actual %0b",
                             $time, verdict, o_is_valid);
                    mismatches++;
                end
            end
        end
    end

    // The result side draws a fresh random stall stretch, possibly empty, after every transfer.
    always @(posedge i_clk) begin
        if (o_valid && !i_stall)
            stall_left = draw_wait(stall_streak);
        else if (stall_left > 0)
            stall_left--;
        i_stall <= (stall_left > 0);
    end

    // Watchdog on cycles in which neither channel moves a transfer and the mode is not written.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_require_prefix_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one character and hold it until it transfers.
    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        gap = draw_wait(send_streak);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= code;
        i_last_char <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_string(input int pinned);
        pinned_verdicts.push_back(pinned);
        for (int k = 0; k < text_q.size(); k++)
            send_char(text_q[k], k == text_q.size() - 1);
    endtask

    task automatic drain_results();
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // The mode register changes only once the block has gone quiet.
    task automatic load_prefix_mode(input bit mode);
        i_valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_require_prefix_we <= 1'b1;
        i_require_prefix    <= mode;
        @(posedge i_clk);
        prefix_mode = mode;
        i_require_prefix_we <= 1'b0;
    endtask

    // Decimal digits of a value, now and then with leading zeros.
    function automatic void push_decimal(input int value);
        string digits;
        digits = $sformatf("%0d", value);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2)) text_q.push_back(ZERO_CODE);
        for (int k = 0; k < digits.len(); k++)
            text_q.push_back(digits[k]);
    endfunction

    // Mostly well-formed addresses with random content, some edited, some noise.
    task automatic make_random_string();
        int    shape;
        int    fields;
        int    pick;
        int    pos;
        bit    add_prefix;
        t_edit edit;
        text_q.delete();
        shape = $urandom_range(0, 9);
        if (shape == 9) begin
            repeat ($urandom_range(1, 20)) begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    text_q.push_back(ZERO_CODE + 8'($urandom_range(0, 9)));
                else if (pick < 6)
                    text_q.push_back(DOT_CODE);
                else if (pick == 6)
                    text_q.push_back(SLASH_CODE);
                else
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            fields = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
            for (int k = 0; k < fields; k++) begin
                if (k > 0)
                    text_q.push_back(DOT_CODE);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    push_decimal($urandom_range(256, 999));
                else if (pick < 5)
                    push_decimal($urandom_range(0, 9));
                else
                    push_decimal($urandom_range(0, 255));
            end

            // Usually the suffix that the mode asks for, sometimes the wrong shape.
            add_prefix = prefix_mode ? ($urandom_range(0, 11) != 0)
                                     : ($urandom_range(0, 11) == 0);
            if (add_prefix) begin
                text_q.push_back(SLASH_CODE);
                pick = $urandom_range(0, 15);
                if (pick == 1)
                    push_decimal($urandom_range(33, 99));
                else if (pick == 2)
                    push_decimal($urandom_range(100000, 999999));
                else if (pick > 2)
                    push_decimal($urandom_range(0, PREFIX_TOP));
            end

            // Broken sequences: a character replaced, dropped, or a separator added.
            if (shape >= 7) begin
                repeat ($urandom_range(1, 2)) begin
                    pos  = $urandom_range(0, text_q.size() - 1);
                    edit = t_edit'($urandom_range(0, 3));
                    case (edit)
                        EDIT_REPLACE: text_q[pos] = 8'($urandom_range(0, 255));
                        EDIT_DROP:    text_q.delete(pos);
                        EDIT_DOT:     text_q.insert(pos, DOT_CODE);
                        EDIT_SLASH:   text_q.insert(pos, SLASH_CODE);
                    endcase
                    if (text_q.size() == 0)
                        text_q.push_back(ZERO_CODE);
                end
            end
        end
    endtask

    // Reset, the directed probes, then random phases under changing modes.
    initial begin : stimulus
        logic [7:0] code;
        int         phase;
        int         strings_left;
        int         random_chars;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < $size(probes); k++) begin
            if (k == 0 || probes[k].mode != prefix_mode)
                load_prefix_mode(probes[k].mode);
            text_q.delete();
            for (int j = 0; j < probes[k].text.len(); j++) begin
                code = probes[k].text[j];
                if (code == NUL_MARK)
                    code = 8'h00;
                else if (code == TOP_MARK)
                    code = 8'hFF;
                text_q.push_back(code);
            end
            send_string(probes[k].verdict);
        end

        phase        = 0;
        random_chars = 0;
        while (random_chars < RANDOM_CHARS) begin
            if (phase == 0)
                load_prefix_mode(1'b1);
            else if (phase == 1)
                load_prefix_mode(1'b0);
            else
                load_prefix_mode($urandom_range(0, 1));
            strings_left = $urandom_range(10, 30);
            while (strings_left > 0 && random_chars < RANDOM_CHARS) begin
                make_random_string();
                random_chars += text_q.size();
                send_string(PREDICTED);
                strings_left--;
            end
            phase++;
        end

        // Let the last results arrive, then keep watching for strays.
        i_valid <= 1'b0;
        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/core/icv_pkg.sv
rtl/core/ipv4_cidr_text_validator.sv
verif/ipv4_cidr_text_validator_test.sv
